// File: design/zcd_pkg.sv
// shared types and constants for the zip central directory parser
package zcd_pkg;
  localparam logic [31:0] SigEnd   = 32'h06054B50;
  localparam logic [31:0] SigEntry = 32'h02014B50;
  localparam logic [16:0] EntriesMax = 17'd1024;
  localparam logic [16:0] NameMax    = 17'd256;
  localparam logic [5:0]  EntryFixed = 6'd46;
  localparam logic [4:0]  EndFixed   = 5'd22;
  localparam logic [3:0]  MethodDeflate = 4'd8;

  localparam logic [1:0] KindName    = 2'd0;
  localparam logic [1:0] KindSummary = 2'd1;
  localparam logic [1:0] KindStatus  = 2'd2;

  localparam logic [3:0] StOk = 4'd0, StSig = 4'd1, StSplit = 4'd2, StCount = 4'd3,
    StMany = 4'd4, StComment = 4'd5, StDir = 4'd6, StTrunc = 4'd7, StDisk = 4'd8,
    StCrypt = 4'd9, StMethod = 4'd10, StName = 4'd11, StLimit = 4'd12;

  localparam logic [1:0] RegArchive = 2'd0, RegStart = 2'd1, RegCap = 2'd2, RegLimit = 2'd3;

  typedef enum logic [6:0] {
    PhSig     = 7'b0000001,
    PhHeader  = 7'b0000010,
    PhName    = 7'b0000100,
    PhSkip    = 7'b0001000,
    PhEnd     = 7'b0010000,
    PhComment = 7'b0100000,
    PhDone    = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic [31:0] archive_size;
    logic [31:0] directory_start;
    logic [15:0] entry_capacity;
    logic [31:0] expand_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [15:0] entry_index;
    logic [3:0]  method;
    logic [31:0] crc_value;
    logic [31:0] packed_size;
    logic [31:0] plain_size;
    logic [31:0] header_offset;
    logic [3:0]  status;
    logic        last;
  } result_t;
endpackage

// File: design/zcd_regs.sv
// apb configuration registers
module zcd_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output zcd_pkg::cfg_t     cfg_o
);
  zcd_pkg::cfg_t cfg_q;
  logic [1:0] idx;
  assign idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.archive_size    <= '0;
      cfg_q.directory_start <= '0;
      cfg_q.entry_capacity  <= 16'hFFFF;
      cfg_q.expand_limit    <= 32'hFFFF_FFFF;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        zcd_pkg::RegArchive: cfg_q.archive_size    <= pwdata;
        zcd_pkg::RegStart:   cfg_q.directory_start <= pwdata;
        zcd_pkg::RegCap:     cfg_q.entry_capacity  <= pwdata[15:0];
        zcd_pkg::RegLimit:   cfg_q.expand_limit    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      zcd_pkg::RegArchive: prdata = cfg_q.archive_size;
      zcd_pkg::RegStart:   prdata = cfg_q.directory_start;
      zcd_pkg::RegCap:     prdata = {16'd0, cfg_q.entry_capacity};
      zcd_pkg::RegLimit:   prdata = cfg_q.expand_limit;
      default:             prdata = '0;
    endcase
  end
  assign cfg_o = cfg_q;
endmodule

// File: design/zcd_parse.sv
// byte parser: record phases, field capture and checks
module zcd_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  zcd_pkg::cfg_t        cfg_i,
  input  logic                 in_take_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_stream_i,
  output logic                 res_valid_o,
  output zcd_pkg::result_t     res_o
);
  zcd_pkg::phase_e phase_q, phase_d;
  logic [17:0] pos_q, pos_d;
  logic [31:0] sw_q, sw_d;
  logic [15:0] flags_q, flags_d, meth_q, meth_d, name_q, name_d, disk_q, disk_d;
  logic [16:0] tail_q, tail_d;
  logic [31:0] crc_q, crc_d, pk_q, pk_d, pl_q, pl_d, off_q, off_d;
  logic [15:0] seen_q, seen_d;
  logic [31:0] dbytes_q, dbytes_d;
  logic [32:0] total_q, total_d;
  // end record fields without an entry slot; the size, offset and comment length reuse entry slots
  logic [15:0] edisk_q, edisk_d, edd_q, edd_d, eon_q, eon_d, ecnt_q, ecnt_d;

  logic [31:0] sh;
  logic [15:0] hi;
  logic [16:0] cap;
  logic [33:0] cur, asz;
  logic [34:0] span_end;
  logic [33:0] eocd_end, ooff, osz;
  logic        emit, fin;
  logic [3:0]  st;
  zcd_pkg::result_t r;

  assign sh  = {data_byte_i, sw_q[31:8]};
  assign hi  = sh[31:16];
  assign cap = ({1'b0, cfg_i.entry_capacity} < zcd_pkg::EntriesMax)
             ? {1'b0, cfg_i.entry_capacity} : zcd_pkg::EntriesMax;
  assign cur = {2'b0, cfg_i.directory_start} + {2'b0, dbytes_q};
  assign asz = {2'b0, cfg_i.archive_size};
  assign span_end = {1'b0, cur} + 35'd1 + {18'd0, name_q} + {18'd0, tail_q};
  assign eocd_end = cur + {29'd0, zcd_pkg::EndFixed} + {18'd0, hi};
  assign ooff = {2'b0, off_q};
  assign osz  = {2'b0, pk_q};

  always_comb begin
    phase_d = phase_q; pos_d = pos_q; sw_d = sw_q;
    flags_d = flags_q; meth_d = meth_q; name_d = name_q; disk_d = disk_q; tail_d = tail_q;
    crc_d = crc_q; pk_d = pk_q; pl_d = pl_q; off_d = off_q;
    seen_d = seen_q; dbytes_d = dbytes_q; total_d = total_q;
    edisk_d = edisk_q; edd_d = edd_q; eon_d = eon_q; ecnt_d = ecnt_q;
    emit = 1'b0; fin = 1'b0; st = zcd_pkg::StOk;
    r = '0;
    r.entry_index = seen_q;
    unique case (phase_q)
      zcd_pkg::PhSig: begin
        sw_d = sh;
        if (pos_q < 18'd3) begin
          pos_d = pos_q + 18'd1;
        end else if (sh == zcd_pkg::SigEntry) begin
          if ({1'b0, seen_q} >= cap) begin
            fin = 1'b1; st = zcd_pkg::StMany;
          end else if (cur > asz || asz - cur < 34'd46) begin
            fin = 1'b1; st = zcd_pkg::StTrunc;
          end else begin
            dbytes_d = dbytes_q + 32'd4; pos_d = 18'd4; phase_d = zcd_pkg::PhHeader;
          end
        end else if (sh == zcd_pkg::SigEnd) begin
          pos_d = 18'd4; phase_d = zcd_pkg::PhEnd;
        end else begin
          fin = 1'b1; st = zcd_pkg::StSig;
        end
      end
      zcd_pkg::PhHeader: begin
        sw_d = sh; dbytes_d = dbytes_q + 32'd1; pos_d = pos_q + 18'd1;
        case (pos_q)
          18'd9:  flags_d = hi;
          18'd11: meth_d = hi;
          18'd19: crc_d = sh;
          18'd23: pk_d = sh;
          18'd27: pl_d = sh;
          18'd29: name_d = hi;
          18'd31: tail_d = {1'b0, hi};
          18'd33: tail_d = tail_q + {1'b0, hi};
          18'd35: disk_d = hi;
          18'd45: begin
            off_d = sh;
            // cursor here is one byte short of the header end
            if ({1'b0, cur} + 35'd1 > {1'b0, asz} + 35'd46
                || span_end > {1'b0, asz}) begin
              fin = 1'b1; st = zcd_pkg::StTrunc;
            end else if (disk_q != 16'd0) begin
              fin = 1'b1; st = zcd_pkg::StDisk;
            end else if (flags_q[0]) begin
              fin = 1'b1; st = zcd_pkg::StCrypt;
            end else if (meth_q != 16'd0 && meth_q != {12'd0, zcd_pkg::MethodDeflate}) begin
              fin = 1'b1; st = zcd_pkg::StMethod;
            end else if (name_q == 16'd0 || {1'b0, name_q} >= zcd_pkg::NameMax) begin
              fin = 1'b1; st = zcd_pkg::StName;
            end else if (pl_q > cfg_i.expand_limit
                         || total_q + {1'b0, pl_q} > {1'b0, cfg_i.expand_limit}) begin
              fin = 1'b1; st = zcd_pkg::StLimit;
            end else begin
              total_d = total_q + {1'b0, pl_q};
              emit = 1'b1;
              r.kind = zcd_pkg::KindSummary;
              r.method = meth_q[3:0];
              r.crc_value = crc_q; r.packed_size = pk_q;
              r.plain_size = pl_q; r.header_offset = sh;
              phase_d = zcd_pkg::PhName; pos_d = '0;
            end
          end
          default: ;
        endcase
      end
      zcd_pkg::PhName: begin
        dbytes_d = dbytes_q + 32'd1;
        emit = 1'b1; r.kind = zcd_pkg::KindName; r.name_char = data_byte_i;
        pos_d = pos_q + 18'd1;
        if (pos_d >= {2'b0, name_q}) begin
          pos_d = '0;
          if (tail_q == 17'd0) begin
            seen_d = seen_q + 16'd1; phase_d = zcd_pkg::PhSig;
          end else begin
            phase_d = zcd_pkg::PhSkip;
          end
        end
      end
      zcd_pkg::PhSkip: begin
        dbytes_d = dbytes_q + 32'd1;
        pos_d = pos_q + 18'd1;
        if (pos_d >= {1'b0, tail_q}) begin
          seen_d = seen_q + 16'd1; phase_d = zcd_pkg::PhSig; pos_d = '0;
        end
      end
      zcd_pkg::PhEnd: begin
        sw_d = sh; pos_d = pos_q + 18'd1;
        case (pos_q)
          18'd5:  edisk_d = hi;
          18'd7:  edd_d = hi;
          18'd9:  eon_d = hi;
          18'd11: ecnt_d = hi;
          18'd15: pk_d = sh;
          18'd19: off_d = sh;
          18'd21: begin
            name_d = hi;
            if (edisk_q != 16'd0 || edd_q != 16'd0) begin
              fin = 1'b1; st = zcd_pkg::StSplit;
            end else if (eon_q != ecnt_q || ecnt_q == 16'd0 || ecnt_q != seen_q) begin
              fin = 1'b1; st = zcd_pkg::StCount;
            end else if ({1'b0, ecnt_q} > cap) begin
              fin = 1'b1; st = zcd_pkg::StMany;
            end else if (eocd_end != asz) begin
              fin = 1'b1; st = zcd_pkg::StComment;
            end else if (ooff > asz || osz > asz - ooff || ooff + osz > cur
                         || off_q != cfg_i.directory_start || pk_q != dbytes_q) begin
              fin = 1'b1; st = zcd_pkg::StDir;
            end else if (hi == 16'd0) begin
              fin = 1'b1; st = zcd_pkg::StOk;
            end else begin
              phase_d = zcd_pkg::PhComment; pos_d = '0;
            end
          end
          default: ;
        endcase
      end
      zcd_pkg::PhComment: begin
        pos_d = pos_q + 18'd1;
        if (pos_d >= {2'b0, name_q}) begin
          fin = 1'b1; st = zcd_pkg::StOk;
        end
      end
      zcd_pkg::PhDone: ;
      default: ;
    endcase
    if (phase_q != zcd_pkg::PhDone && !fin && end_of_stream_i) begin
      fin = 1'b1; st = zcd_pkg::StTrunc;
    end
    if (fin) begin
      phase_d = zcd_pkg::PhDone;
      emit = 1'b1;
      r = '0;
      r.kind = zcd_pkg::KindStatus;
      r.entry_index = seen_d;
      r.status = st;
      r.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= zcd_pkg::PhSig; pos_q <= '0; sw_q <= '0;
      flags_q <= '0; meth_q <= '0; name_q <= '0; disk_q <= '0; tail_q <= '0;
      crc_q <= '0; pk_q <= '0; pl_q <= '0; off_q <= '0;
      seen_q <= '0; dbytes_q <= '0; total_q <= '0;
      edisk_q <= '0; edd_q <= '0; eon_q <= '0; ecnt_q <= '0;
      res_valid_o <= 1'b0;
    end else if (in_take_i) begin
      phase_q <= phase_d; pos_q <= pos_d; sw_q <= sw_d;
      flags_q <= flags_d; meth_q <= meth_d; name_q <= name_d; disk_q <= disk_d;
      tail_q <= tail_d; crc_q <= crc_d; pk_q <= pk_d; pl_q <= pl_d; off_q <= off_d;
      seen_q <= seen_d; dbytes_q <= dbytes_d; total_q <= total_d;
      edisk_q <= edisk_d; edd_q <= edd_d; eon_q <= eon_d; ecnt_q <= ecnt_d;
      res_valid_o <= emit;
    end else begin
      res_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take_i) res_o <= r;
  end
endmodule

// File: design/zcd_outq.sv
// two-entry output skid queue
module zcd_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  zcd_pkg::result_t  push_data_i,
  output logic              room_o,
  output logic              valid_o,
  output zcd_pkg::result_t  data_o,
  input  logic              stall_i
);
  zcd_pkg::result_t mem_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic pop;
  assign pop = valid_o && !stall_i;
  assign valid_o = cnt_q != 2'd0;
  assign data_o = mem_q[rd_q];
  // room for one more while one may still be in flight
  assign room_o = cnt_q == 2'd0 || (cnt_q == 2'd1 && (!push_i || pop))
                  || (cnt_q == 2'd2 && !push_i && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end
endmodule

// File: design/zip_central_directory_parser.sv
// top level of the zip central directory parser
// Takes one archive byte per cycle, while the output queue has room, from the
// central directory start and emits name bytes, entry summaries and one final
// status; every byte passes through a single register stage, with a two-entry
// output queue so input can keep flowing while a result waits; after the final
// status all bytes are taken and dropped until reset.
module zip_central_directory_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  name_char_o,
  output logic [15:0] entry_index_o,
  output logic [3:0]  method_o,
  output logic [31:0] crc_value_o,
  output logic [31:0] packed_size_o,
  output logic [31:0] plain_size_o,
  output logic [31:0] header_offset_o,
  output logic [3:0]  status_o,
  output logic        last_o
);
  zcd_pkg::cfg_t cfg;
  zcd_pkg::result_t res, q;
  logic res_valid, room, take;

  assign pready = 1'b1;
  assign in_stall_o = !room;
  assign take = in_valid_i && room;

  zcd_regs u_regs (.clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
                   .prdata, .cfg_o(cfg));

  zcd_parse u_parse (.clk_i, .rst_ni, .cfg_i(cfg), .in_take_i(take), .data_byte_i,
                     .end_of_stream_i, .res_valid_o(res_valid), .res_o(res));

  zcd_outq u_outq (.clk_i, .rst_ni, .push_i(res_valid), .push_data_i(res), .room_o(room),
                   .valid_o(out_valid_o), .data_o(q), .stall_i(out_stall_i));

  assign kind_o = q.kind;
  assign name_char_o = q.name_char;
  assign entry_index_o = q.entry_index;
  assign method_o = q.method;
  assign crc_value_o = q.crc_value;
  assign packed_size_o = q.packed_size;
  assign plain_size_o = q.plain_size;
  assign header_offset_o = q.header_offset;
  assign status_o = q.status;
  assign last_o = q.last;
endmodule
